/* rtl/debounced_button_mode_blinker_unit_defines.svh */
// Assertion helpers used by the top-level RTL file.
`ifndef DEBOUNCED_BUTTON_MODE_BLINKER_UNIT_DEFINES_SVH
`define DEBOUNCED_BUTTON_MODE_BLINKER_UNIT_DEFINES_SVH

// Clocked property, suspended while reset is applied.
`define DBMB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Something that must never be seen at a clock edge.
`define DBMB_NEVER(label, cond, msg) \
  `DBMB_ASSERT(label, !(cond), msg)

`endif

/* rtl/dbmb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package dbmb_pkg;

  localparam int unsigned DEB_W    = 8;
  localparam int unsigned HOLD_W   = 12;
  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [HOLD_W-1:0]   EDGE_MAX   = '1;
  localparam logic [PERIOD_W-1:0] TOGGLE_MAX = '1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_SLOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MID  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_FAST = 3'd4;

  localparam logic [DEB_W-1:0]    DEBOUNCE_RST    = 8'd15;
  localparam logic [HOLD_W-1:0]   HOLD_RST        = 12'd3000;
  localparam logic [PERIOD_W-1:0] PERIOD_SLOW_RST = 10'd1000;
  localparam logic [PERIOD_W-1:0] PERIOD_MID_RST  = 10'd200;
  localparam logic [PERIOD_W-1:0] PERIOD_FAST_RST = 10'd100;

  localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SLOW = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MID  = 2'd2;

  typedef struct packed {
    logic [DEB_W-1:0]    debounce_ticks;
    logic [HOLD_W-1:0]   hold_ticks;
    logic [PERIOD_W-1:0] period_slow;
    logic [PERIOD_W-1:0] period_mid;
    logic [PERIOD_W-1:0] period_fast;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic                last_level;
    logic                settling;
    logic                held;
    logic [HOLD_W-1:0]   since_edge;
    logic [PERIOD_W-1:0] since_toggle;
    logic                lit;
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode_now;
    logic              led_lit;
    logic [MODE_W-1:0] led_color;
  } result_t;

endpackage
`default_nettype wire

/* rtl/dbmb_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// One tick of the blinker and debouncer: next state and the result.
module dbmb_step (
  input  wire dbmb_pkg::cfg_t    cfg,
  input  wire dbmb_pkg::state_t  cur,
  input  wire logic              button_level,
  output dbmb_pkg::state_t       nxt,
  output dbmb_pkg::result_t      res
);

  logic                              pressed;
  logic                              change;
  logic                              settled;
  logic [dbmb_pkg::HOLD_W-1:0]       edge_inc;
  logic [dbmb_pkg::HOLD_W-1:0]       edge_cnt;
  logic [dbmb_pkg::PERIOD_W-1:0]     toggle_inc;
  logic [dbmb_pkg::PERIOD_W-1:0]     period;

  assign pressed = ~button_level;
  assign change  = pressed != cur.last_level;

  always_comb begin
    edge_inc   = (cur.since_edge == dbmb_pkg::EDGE_MAX) ? cur.since_edge
                                                        : cur.since_edge + 1'b1;
    toggle_inc = (cur.since_toggle == dbmb_pkg::TOGGLE_MAX) ? cur.since_toggle
                                                            : cur.since_toggle + 1'b1;
    case (cur.mode)
      dbmb_pkg::MODE_SLOW: period = cfg.period_slow;
      dbmb_pkg::MODE_MID:  period = cfg.period_mid;
      default:             period = cfg.period_fast;
    endcase
  end

  assign edge_cnt = change ? '0 : edge_inc;
  assign settled  = (cur.settling | change) &&
                    (edge_cnt >= {{(dbmb_pkg::HOLD_W-dbmb_pkg::DEB_W){1'b0}},
                                  cfg.debounce_ticks});

  always_comb begin
    nxt              = cur;
    nxt.since_edge   = edge_cnt;
    nxt.since_toggle = toggle_inc;
    nxt.last_level   = pressed;
    nxt.settling     = cur.settling | change;

    // blink step works on the mode from before this tick
    if (cur.mode == dbmb_pkg::MODE_OFF) begin
      nxt.lit = 1'b0;
    end else if (toggle_inc >= period) begin
      nxt.lit          = ~cur.lit;
      nxt.since_toggle = '0;
    end

    if (settled) begin
      nxt.settling = 1'b0;
      if (pressed) begin
        nxt.mode         = cur.mode + 1'b1;
        nxt.since_toggle = '0;
        nxt.held         = 1'b1;
      end else begin
        nxt.held = 1'b0;
      end
    end

    if (nxt.held && (edge_cnt >= cfg.hold_ticks)) begin
      nxt.mode = dbmb_pkg::MODE_OFF;
    end
  end

  always_comb begin
    res.mode_now  = nxt.mode;
    res.led_lit   = nxt.lit;
    res.led_color = (nxt.lit && nxt.mode != dbmb_pkg::MODE_OFF) ? nxt.mode
                                                                 : dbmb_pkg::MODE_OFF;
  end

endmodule
`default_nettype wire

/* rtl/debounced_button_mode_blinker_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Debounced button mode selector with a blinking LED. Each input request is one
// millisecond tick carrying the raw active-low button level; each yields exactly one
// result with the mode (0 off, 1 to 3 blink), the LED state and its colour after that
// tick. A tick is taken every clock cycle: the state update is a single combinational
// pass into the state registers, and the result sits in an output register that takes
// a new value whenever it is empty or being drained, so the input stalls only while
// a result is held up by a stalled output; the result appears in the cycle after accept.
// The user must write settings (debounce, hold and the three blink periods) on the cfg
// port only while no tick is in flight; the block does not enforce it. Unknown indexes are ignored.
`include "debounced_button_mode_blinker_unit_defines.svh"
module debounced_button_mode_blinker_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [dbmb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dbmb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_button_level,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [dbmb_pkg::MODE_W-1:0]              out_mode_now,
  output logic                                     out_led_lit,
  output logic [dbmb_pkg::MODE_W-1:0]              out_led_color
);

  dbmb_pkg::cfg_t    cfg_r;
  dbmb_pkg::state_t  state_r;
  dbmb_pkg::state_t  state_nxt;
  dbmb_pkg::result_t res_nxt;
  dbmb_pkg::result_t res_r;
  logic              out_valid_r;
  logic              in_take;

  dbmb_step u_step (
    .cfg          (cfg_r),
    .cur          (state_r),
    .button_level (in_button_level),
    .nxt          (state_nxt),
    .res          (res_nxt)
  );

  assign in_stall = out_valid_r & out_stall;
  assign in_take  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks <= dbmb_pkg::DEBOUNCE_RST;
      cfg_r.hold_ticks     <= dbmb_pkg::HOLD_RST;
      cfg_r.period_slow    <= dbmb_pkg::PERIOD_SLOW_RST;
      cfg_r.period_mid     <= dbmb_pkg::PERIOD_MID_RST;
      cfg_r.period_fast    <= dbmb_pkg::PERIOD_FAST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dbmb_pkg::REG_DEBOUNCE:    cfg_r.debounce_ticks <= cfg_wdata[dbmb_pkg::DEB_W-1:0];
        dbmb_pkg::REG_HOLD:        cfg_r.hold_ticks     <= cfg_wdata[dbmb_pkg::HOLD_W-1:0];
        dbmb_pkg::REG_PERIOD_SLOW: cfg_r.period_slow    <= cfg_wdata[dbmb_pkg::PERIOD_W-1:0];
        dbmb_pkg::REG_PERIOD_MID:  cfg_r.period_mid     <= cfg_wdata[dbmb_pkg::PERIOD_W-1:0];
        dbmb_pkg::REG_PERIOD_FAST: cfg_r.period_fast    <= cfg_wdata[dbmb_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        state_r <= state_nxt;
      end
      if (in_take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_mode_now  = res_r.mode_now;
  assign out_led_lit   = res_r.led_lit;
  assign out_led_color = res_r.led_color;

  `DBMB_ASSERT(a_take_gives_result, in_take |=> out_valid_r, "accepted tick gave no result")
  `DBMB_NEVER(a_colour_mismatch, out_valid_r && out_led_color != dbmb_pkg::MODE_OFF && (!out_led_lit || out_led_color != out_mode_now), "colour disagrees with lit flag or mode")
  `DBMB_ASSERT(a_off_clears_lit, in_take && state_r.mode == dbmb_pkg::MODE_OFF |=> !state_r.lit, "LED not cleared in off mode")
  `DBMB_ASSERT(a_edge_restarts, in_take && (in_button_level == state_r.last_level) |=> state_r.since_edge == '0, "level change did not restart debounce timer")

endmodule
`default_nettype wire
